@@ design/mtlc_pkg.sv @@
// Shared types, constants and codes for the mesh triangle loop checker.
`default_nettype none
package mtlc_pkg;

  localparam int EDGE_DEPTH     = 1024;
  localparam int POINT_BITS     = 16;
  localparam int EDGE_ADDR_BITS = $clog2(EDGE_DEPTH);
  localparam int SLOT_BITS      = 10;
  localparam int CORNER_BITS    = 16;
  localparam int COUNT_BITS     = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_WRITE_EDGE = 2'd0,
    OP_CHECK      = 2'd1,
    OP_BEGIN_MESH = 2'd2,
    OP_UNUSED     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_VALID   = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_SKIPPED = 2'd2,
    STATUS_UNUSED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_B,
    ST_READ_C,
    ST_EVAL
  } state_t;

  typedef logic [POINT_BITS-1:0] point_t;

  // One edge table entry: first endpoint in the low half.
  typedef struct packed {
    point_t second;
    point_t first;
  } edge_word_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [SLOT_BITS-1:0] edge_slot;
    logic [15:0]          point_first;
    logic [15:0]          point_second;
    logic [SLOT_BITS-1:0] edge_ref_a;
    logic                 forward_a;
    logic [SLOT_BITS-1:0] edge_ref_b;
    logic                 forward_b;
    logic [SLOT_BITS-1:0] edge_ref_c;
    logic                 forward_c;
    logic                 last_face;
  } req_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [CORNER_BITS-1:0] corner_a;
    logic [CORNER_BITS-1:0] corner_b;
    logic [CORNER_BITS-1:0] corner_c;
    logic [COUNT_BITS-1:0]  face_number;
    logic                   mesh_ready;
  } res_item_t;

  // Per-face control handed to the loop evaluator.
  typedef struct packed {
    logic                  forward_a;
    logic                  forward_b;
    logic                  forward_c;
    logic                  in_range_a;
    logic                  in_range_b;
    logic                  in_range_c;
    logic                  last_face;
    logic                  error_seen;
    logic [COUNT_BITS-1:0] face_number;
  } face_ctl_t;

  function automatic logic slot_in_range(input logic [SLOT_BITS-1:0] slot);
    return 32'(slot) < 32'(EDGE_DEPTH);
  endfunction

endpackage
`default_nettype wire

@@ design/mtlc_req_if.sv @@
// Request channel: valid/ready handshake carrying one input item.
`default_nettype none
interface mtlc_req_if;
  logic                valid;
  logic                ready;
  mtlc_pkg::req_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

@@ design/mtlc_res_if.sv @@
// Result channel: valid/ready handshake carrying one result item.
`default_nettype none
interface mtlc_res_if;
  logic                valid;
  logic                ready;
  mtlc_pkg::res_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

@@ design/mesh_triangle_loop_check.sv @@
// Top level: edge table memory, read sequencer and result register.
// Triangle items: edges A, B, C are read in turn (accept, ST_READ_B, ST_READ_C)
// via the single edge table port, taking no new item; ST_EVAL loads the result.
// Edge-write and begin-mesh items return no result.
// A new item is taken while a finished result still waits in the output register.
// Synchronous reset clears the sequencer, error flag, face counter and result valid;
// the edge table is not cleared and needs no clearing pass.
`default_nettype none
module mesh_triangle_loop_check (
  input  wire logic    clk,
  input  wire logic    rst,
  mtlc_req_if.sink     request,
  mtlc_res_if.source   result
);

  mtlc_pkg::edge_word_t edge_mem [mtlc_pkg::EDGE_DEPTH];
  mtlc_pkg::edge_word_t rdata;
  mtlc_pkg::edge_word_t edge_a;
  mtlc_pkg::edge_word_t edge_b;
  mtlc_pkg::edge_word_t wdata;
  logic [mtlc_pkg::EDGE_ADDR_BITS-1:0] mem_addr;
  logic mem_we;
  logic mem_re;

  mtlc_pkg::state_t state, state_next;
  mtlc_pkg::req_item_t face;
  mtlc_pkg::res_item_t out_item;
  mtlc_pkg::res_item_t eval_res;
  mtlc_pkg::face_ctl_t ctl;
  logic out_valid;
  logic out_free;
  logic accept;
  logic take_check;
  logic eval_fire;
  logic eval_fail;
  logic error_seen;
  logic [mtlc_pkg::COUNT_BITS-1:0] face_counter;

  assign out_free   = !out_valid || result.ready;
  assign accept     = request.valid && request.ready;
  assign take_check = accept && (request.item.op == mtlc_pkg::OP_CHECK);
  assign eval_fire  = (state == mtlc_pkg::ST_EVAL) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtlc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    request.ready = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = mtlc_pkg::EDGE_ADDR_BITS'(request.item.edge_ref_a);
    unique case (state)
      mtlc_pkg::ST_IDLE: begin
        request.ready = !rst;
        mem_re        = take_check;
        if (accept && request.item.op == mtlc_pkg::OP_WRITE_EDGE) begin
          mem_addr = mtlc_pkg::EDGE_ADDR_BITS'(request.item.edge_slot);
        end
        if (take_check) begin
          state_next = mtlc_pkg::ST_READ_B;
        end
      end
      mtlc_pkg::ST_READ_B: begin
        mem_re     = 1'b1;
        mem_addr   = mtlc_pkg::EDGE_ADDR_BITS'(face.edge_ref_b);
        state_next = mtlc_pkg::ST_READ_C;
      end
      mtlc_pkg::ST_READ_C: begin
        mem_re     = 1'b1;
        mem_addr   = mtlc_pkg::EDGE_ADDR_BITS'(face.edge_ref_c);
        state_next = mtlc_pkg::ST_EVAL;
      end
      mtlc_pkg::ST_EVAL: begin
        // Overlap the next item with loading the result register.
        request.ready = out_free;
        mem_re        = take_check;
        if (accept && request.item.op == mtlc_pkg::OP_WRITE_EDGE) begin
          mem_addr = mtlc_pkg::EDGE_ADDR_BITS'(request.item.edge_slot);
        end
        if (out_free) begin
          state_next = take_check ? mtlc_pkg::ST_READ_B : mtlc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mtlc_pkg::ST_IDLE;
      end
    endcase
  end

  assign mem_we = accept && (request.item.op == mtlc_pkg::OP_WRITE_EDGE) &&
                  mtlc_pkg::slot_in_range(request.item.edge_slot);
  assign wdata.first  = mtlc_pkg::POINT_BITS'(request.item.point_first);
  assign wdata.second = mtlc_pkg::POINT_BITS'(request.item.point_second);

  // Single port: a write and a read never share a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      edge_mem[mem_addr] <= wdata;
    end
    if (mem_re) begin
      rdata <= edge_mem[mem_addr];
    end
  end

  // Hold the triangle and edges A and B while the reads proceed.
  always_ff @(posedge clk) begin
    if (take_check) begin
      face <= request.item;
    end
    if (state == mtlc_pkg::ST_READ_B) begin
      edge_a <= rdata;
    end
    if (state == mtlc_pkg::ST_READ_C) begin
      edge_b <= rdata;
    end
  end

  always_comb begin
    ctl.forward_a   = face.forward_a;
    ctl.forward_b   = face.forward_b;
    ctl.forward_c   = face.forward_c;
    ctl.in_range_a  = mtlc_pkg::slot_in_range(face.edge_ref_a);
    ctl.in_range_b  = mtlc_pkg::slot_in_range(face.edge_ref_b);
    ctl.in_range_c  = mtlc_pkg::slot_in_range(face.edge_ref_c);
    ctl.last_face   = face.last_face;
    ctl.error_seen  = error_seen;
    ctl.face_number = face_counter;
  end

  mtlc_loop_eval u_loop_eval (
    .edge_a (edge_a),
    .edge_b (edge_b),
    .edge_c (rdata),
    .ctl    (ctl),
    .res    (eval_res),
    .fail   (eval_fail)
  );

  // Begin-mesh taken in the evaluation cycle comes later in order, so it wins.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_seen   <= 1'b0;
      face_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept && request.item.op == mtlc_pkg::OP_BEGIN_MESH) begin
        error_seen   <= 1'b0;
        face_counter <= '0;
      end else if (eval_fire) begin
        if (eval_fail) begin
          error_seen <= 1'b1;
        end
        if (face_counter != mtlc_pkg::COUNT_MAX) begin
          face_counter <= face_counter + 1'b1;
        end
      end
      if (eval_fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      out_item <= eval_res;
    end
  end

  assign result.valid = out_valid;
  assign result.item  = out_item;

endmodule
`default_nettype wire

@@ design/mtlc_loop_eval.sv @@
// Orients edges A, B and C, checks the closed loop and builds the result item.
`default_nettype none
module mtlc_loop_eval (
  input  mtlc_pkg::edge_word_t edge_a,
  input  mtlc_pkg::edge_word_t edge_b,
  input  mtlc_pkg::edge_word_t edge_c,
  input  mtlc_pkg::face_ctl_t  ctl,
  output mtlc_pkg::res_item_t  res,
  output logic                 fail
);

  mtlc_pkg::point_t s0, e0, s1, e1, s2, e2;
  mtlc_pkg::edge_word_t ea, eb, ec;
  logic bad_loop;

  always_comb begin
    // An out-of-range reference reads as the pair (0, 0).
    ea = ctl.in_range_a ? edge_a : '0;
    eb = ctl.in_range_b ? edge_b : '0;
    ec = ctl.in_range_c ? edge_c : '0;
    s0 = ctl.forward_a ? ea.first : ea.second;
    e0 = ctl.forward_a ? ea.second : ea.first;
    s1 = ctl.forward_b ? eb.first : eb.second;
    e1 = ctl.forward_b ? eb.second : eb.first;
    s2 = ctl.forward_c ? ec.first : ec.second;
    e2 = ctl.forward_c ? ec.second : ec.first;

    bad_loop = (s0 == e0) || (e0 != s1) || (s1 == e1) || (e1 != s2) ||
               (s2 == e2) || (e2 != s0);

    res = '0;
    res.face_number = ctl.face_number;
    fail = 1'b0;
    if (ctl.error_seen) begin
      res.status = mtlc_pkg::STATUS_SKIPPED;
    end else if (bad_loop) begin
      res.status = mtlc_pkg::STATUS_INVALID;
      fail = 1'b1;
    end else begin
      res.status     = mtlc_pkg::STATUS_VALID;
      res.corner_a   = mtlc_pkg::CORNER_BITS'(s0);
      res.corner_b   = mtlc_pkg::CORNER_BITS'(s1);
      res.corner_c   = mtlc_pkg::CORNER_BITS'(s2);
      res.mesh_ready = ctl.last_face;
    end
  end

endmodule
`default_nettype wire
